FILE: design/jsu_pkg.sv
package jsu_pkg;

  // Result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_END    = 3'd1;
  localparam logic [2:0] ST_CUT    = 3'd2;
  localparam logic [2:0] ST_BADESC = 3'd3;
  localparam logic [2:0] ST_BADHEX = 3'd4;
  localparam logic [2:0] ST_UNTERM = 3'd5;

  // Groups held between the front and the back
  localparam int unsigned QDEPTH = 2;

  localparam int unsigned MAX_DATA = 3;

  // All results caused by one input byte: up to three data bytes, then an
  // optional closing status.
  typedef struct packed {
    logic [1:0]                ndata;
    logic [MAX_DATA-1:0][7:0]  data;
    logic                      tail;
    logic [2:0]                tail_status;
  } grp_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    grp_t grp;
  } head_t;

endpackage

FILE: design/jsu_if.sv
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_last;

  modport source (output valid, output in_byte, output in_first, output in_last,
                  input ready);
  modport sink   (input valid, input in_byte, input in_first, input in_last,
                  output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last;

  modport source (output valid, output out_byte, output out_status, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_status, input out_last,
                  output ready);
endinterface

FILE: design/json_string_unescape_decoder.sv
// JSON string body unescaper to UTF-8.
// in_i  : one byte of the string body per transfer, starting after the
//         opening quote; in_first restarts the escape state, in_last marks
//         the end of the available text.
// out_o : decoded results, one per transfer: a data byte (status 0) or a
//         closing status (string end, cut-off escape, bad escape, bad hex,
//         unterminated). out_last flags the final result of an input byte.
// Each result group is registered in the queue before its results are offered.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and the receiver takes it; a completed \uXXXX yields up to
//   three data results (four when the text also ends on it), shown one
//   per cycle by the output serialiser, so the output port sets the rate.
//   Bytes that yield nothing (backslash, hex digits, text after the end)
//   push no group, but are still taken in only while the queue has room.
// The classifier sits in front of a small queue of result groups (QDEPTH
//   entries); input stays ready while the queue has room, even when the
//   receiver stalls, and drops ready only once the queue is full.
// Reset: escape state returns to normal text, the queue empties and no
//   result is offered.
module json_string_unescape_decoder #(
  parameter int unsigned QDEPTH = jsu_pkg::QDEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  jsu_pkg::grp_t  grp;
  jsu_pkg::head_t head;
  logic           push, q_ready, pop;

  // Front: classify each byte and build its result group
  jsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .grp_o     (grp)
  );

  // Queue: hold groups so that front and back stall independently
  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp),
    .ready_o (q_ready),
    .pop_i   (pop),
    .head_o  (head)
  );

  // Back: serialise each group into single result transfers
  jsu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

FILE: design/jsu_front.sv
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsu_in_if.sink        in_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output jsu_pkg::grp_t grp_o
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_HEX3   = 3'd4;
  localparam logic [2:0] MODE_HEX4   = 3'd5;
  localparam logic [2:0] MODE_DONE   = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  logic [2:0]    mode_q, mode_d, mode_cur, mode_n;
  logic [15:0]   acc_q, acc_d, acc_cur, acc_n, acc_sh;
  logic          accept, skip_last, hex_ok;
  logic [3:0]    hex_val;
  logic [7:0]    c;
  jsu_pkg::grp_t grp;

  assign c         = in_i.in_byte;
  assign in_i.ready = q_ready_i;
  assign accept    = in_i.valid & q_ready_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      hex_val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign mode_cur = in_i.in_first ? MODE_NORMAL : mode_q;
  assign acc_cur  = in_i.in_first ? 16'd0 : acc_q;
  assign acc_sh   = {acc_cur[11:0], hex_val};

  always_comb begin
    mode_n    = mode_cur;
    acc_n     = acc_cur;
    skip_last = 1'b0;
    grp       = '0;
    case (mode_cur)
      MODE_NORMAL: begin
        if (c == CH_QUOTE) begin
          grp.tail        = 1'b1;
          grp.tail_status = jsu_pkg::ST_END;
          mode_n          = MODE_DONE;
        end else if (c == CH_BSLASH) begin
          mode_n = MODE_ESC;
        end else begin
          grp.ndata   = 2'd1;
          grp.data[0] = c;
        end
      end
      MODE_ESC: begin
        mode_n      = MODE_NORMAL;
        grp.ndata   = 2'd1;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: grp.data[0] = c;
          CH_B:    grp.data[0] = 8'h08;
          CH_F:    grp.data[0] = 8'h0C;
          CH_N:    grp.data[0] = 8'h0A;
          CH_R:    grp.data[0] = 8'h0D;
          CH_T:    grp.data[0] = 8'h09;
          CH_U: begin
            grp.ndata = 2'd0;
            mode_n    = MODE_HEX1;
            acc_n     = 16'd0;
          end
          default: begin
            grp.ndata       = 2'd0;
            grp.tail        = 1'b1;
            grp.tail_status = jsu_pkg::ST_BADESC;
            mode_n          = MODE_DONE;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (hex_ok) begin
          acc_n  = acc_sh;
          mode_n = mode_cur + 3'd1;
        end else begin
          grp.tail        = 1'b1;
          grp.tail_status = jsu_pkg::ST_BADHEX;
          mode_n          = MODE_DONE;
        end
      end
      MODE_HEX4: begin
        if (hex_ok) begin
          mode_n = MODE_NORMAL;
          acc_n  = 16'd0;
          if (acc_sh <= 16'h007F) begin
            grp.ndata   = 2'd1;
            grp.data[0] = acc_sh[7:0];
          end else if (acc_sh <= 16'h07FF) begin
            grp.ndata   = 2'd2;
            grp.data[0] = 8'hC0 | {3'b000, acc_sh[10:6]};
            grp.data[1] = 8'h80 | {2'b00, acc_sh[5:0]};
          end else begin
            grp.ndata   = 2'd3;
            grp.data[0] = 8'hE0 | {4'b0000, acc_sh[15:12]};
            grp.data[1] = 8'h80 | {2'b00, acc_sh[11:6]};
            grp.data[2] = 8'h80 | {2'b00, acc_sh[5:0]};
          end
        end else begin
          grp.tail        = 1'b1;
          grp.tail_status = jsu_pkg::ST_BADHEX;
          mode_n          = MODE_DONE;
        end
      end
      default: begin
        // finished: drop everything until the next first byte
        mode_n    = MODE_DONE;
        skip_last = 1'b1;
      end
    endcase

    if (in_i.in_last && !skip_last) begin
      if (mode_n == MODE_NORMAL) begin
        grp.tail        = 1'b1;
        grp.tail_status = jsu_pkg::ST_UNTERM;
        mode_n          = MODE_DONE;
      end else if (mode_n != MODE_DONE) begin
        grp.tail        = 1'b1;
        grp.tail_status = jsu_pkg::ST_CUT;
        mode_n          = MODE_DONE;
      end
    end
  end

  assign mode_d = accept ? mode_n : mode_q;
  assign acc_d  = accept ? acc_n : acc_q;
  assign push_o = accept & ((grp.ndata != 2'd0) | grp.tail);
  assign grp_o  = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= 16'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: design/jsu_queue.sv
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QDEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsu_pkg::grp_t  grp_i,
  output logic           ready_o,
  input  logic           pop_i,
  output jsu_pkg::head_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  jsu_pkg::grp_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign ready_o = (count_q != CW'(DEPTH));
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.grp   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= grp_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + CW'(1))
    else $error("push without pop did not grow the queue");

  a_queued_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_o.valid |-> (head_o.grp.ndata != 2'd0) || head_o.grp.tail)
    else $error("empty result group queued");
`endif

endmodule

FILE: design/jsu_back.sv
module jsu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsu_pkg::head_t head_i,
  output logic           pop_o,
  jsu_out_if.source      out_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_data, is_last, xfer;

  assign total   = {1'b0, head_i.grp.ndata} + {2'b00, head_i.grp.tail};
  assign is_data = ({1'b0, idx_q} < {1'b0, head_i.grp.ndata});
  assign is_last = ({1'b0, idx_q} == total - 3'd1);
  assign xfer    = head_i.valid & out_o.ready;

  assign out_o.valid      = head_i.valid;
  assign out_o.out_byte   = is_data ? head_i.grp.data[idx_q] : 8'h00;
  assign out_o.out_status = is_data ? jsu_pkg::ST_DATA : head_i.grp.tail_status;
  assign out_o.out_last   = is_last;

  // Retire the group once its last result has been transferred
  assign pop_o = xfer & is_last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> {1'b0, idx_q} < total)
    else $error("result index beyond group");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0)
    else $error("result index not restarted after group");

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_i.valid && !is_data) |-> is_last)
    else $error("status result not last of group");
`endif

endmodule
